>>> sv/pgdi_pkg.sv
// ----------------------------------------------------------------------------
// pgdi_pkg
// shared sizes, genotype codes, opcodes and lane structs of the packed
// genotype decoder with mean imputation
// ----------------------------------------------------------------------------
package pgdi_pkg;

	localparam int MAX_IND   = 4096;
	localparam int LANES     = 4;
	localparam int IDX_W     = $clog2(MAX_IND);
	localparam int CNT_W     = IDX_W + 1;
	localparam int BANK_W    = $clog2(LANES);
	localparam int ROW_W     = IDX_W - BANK_W;
	localparam int ROWS      = MAX_IND / LANES;
	localparam int FRAC_BITS = 16;
	localparam int DOS_W     = FRAC_BITS + 2;
	localparam int SUM_W     = CNT_W + 1;
	localparam int NUM_W     = SUM_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam int LANE_W    = $clog2(LANES + 1);

	typedef logic [1:0] code_t;

	// genotype codes, low bit of the pair first
	localparam code_t CODE_HOM_A = 2'd0;
	localparam code_t CODE_MISS  = 2'd1;
	localparam code_t CODE_HET   = 2'd2;
	localparam code_t CODE_HOM_B = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_DOSAGE  = 1'b1;

	typedef struct packed {
		logic       slot_ok;
		logic       cand;
		logic       keep;
		logic [1:0] dose;
		logic       miss;
	} lane_res_t;

	typedef struct packed {
		logic [LANE_W-1:0] n_slot;
		logic [LANE_W-1:0] n_keep;
		logic [LANE_W:0]   dose_add;
		logic [LANE_W-1:0] n_miss;
	} merge_t;

	// integer dosage of an observed code, missing gives zero
	function automatic logic [1:0] dose_of(code_t c);
		logic [1:0] d;
		case (c)
			CODE_HOM_A: d = 2'd2;
			CODE_HET:   d = 2'd1;
			default:    d = 2'd0;
		endcase
		return d;
	endfunction

endpackage

>>> sv/pgdi_lane.sv
// ----------------------------------------------------------------------------
// pgdi_lane
// decodes one 2-bit slot: range check, include test, store room, dosage
// ----------------------------------------------------------------------------
module pgdi_lane (
	input  pgdi_pkg::code_t                code,
	input  logic                           incl,
	input  logic [pgdi_pkg::CNT_W-1:0]     slot_idx,
	input  logic [pgdi_pkg::CNT_W-1:0]     eff_total,
	input  logic [pgdi_pkg::CNT_W-1:0]     store_idx,
	output pgdi_pkg::lane_res_t            res
);

	always_comb begin
		res.slot_ok = (slot_idx < eff_total);
		res.cand    = res.slot_ok && incl;
		res.keep    = res.cand && (store_idx < pgdi_pkg::CNT_W'(pgdi_pkg::MAX_IND));
		res.dose    = res.keep ? pgdi_pkg::dose_of(code) : 2'd0;
		res.miss    = res.keep && (code == pgdi_pkg::CODE_MISS);
	end

endmodule

>>> sv/pgdi_merge.sv
// ----------------------------------------------------------------------------
// pgdi_merge
// adds up what the lanes found in one byte
// ----------------------------------------------------------------------------
module pgdi_merge (
	input  pgdi_pkg::lane_res_t res [pgdi_pkg::LANES],
	output pgdi_pkg::merge_t    m
);

	always_comb begin
		m = '0;
		for (int j = 0; j < pgdi_pkg::LANES; j++) begin
			m.n_slot   = m.n_slot + pgdi_pkg::LANE_W'(res[j].slot_ok);
			m.n_keep   = m.n_keep + pgdi_pkg::LANE_W'(res[j].keep);
			m.dose_add = m.dose_add + (pgdi_pkg::LANE_W + 1)'(res[j].dose);
			m.n_miss   = m.n_miss + pgdi_pkg::LANE_W'(res[j].miss);
		end
	end

endmodule

>>> sv/pgdi_div.sv
// ----------------------------------------------------------------------------
// pgdi_div
// restoring divider, one quotient bit per cycle, result held until restart
// ----------------------------------------------------------------------------
module pgdi_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pgdi_pkg::NUM_W-1:0]      num,
	input  logic [pgdi_pkg::CNT_W-1:0]      den,
	output logic                            done,
	output logic [pgdi_pkg::DOS_W-1:0]      quo
);

	logic                           busy_q;
	logic                           done_q;
	logic [pgdi_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [pgdi_pkg::NUM_W-1:0]     num_q;
	logic [pgdi_pkg::CNT_W-1:0]     rem_q;
	logic [pgdi_pkg::CNT_W-1:0]     den_q;
	logic [pgdi_pkg::CNT_W:0]       rem_sh;
	logic                           ge;
	logic [pgdi_pkg::CNT_W:0]       rem_nx;

	always_comb begin
		rem_sh = {rem_q, num_q[pgdi_pkg::NUM_W-1]};
		ge     = (rem_sh >= {1'b0, den_q});
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pgdi_pkg::DIV_CNT_W'(pgdi_pkg::NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - pgdi_pkg::DIV_CNT_W'(1);
			if (cnt_q == pgdi_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pgdi_pkg::NUM_W-2:0], ge};
			rem_q <= rem_nx[pgdi_pkg::CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q[pgdi_pkg::DOS_W-1:0];

endmodule

>>> sv/packed_genotype_decode_impute.sv
// ----------------------------------------------------------------------------
// packed_genotype_decode_impute
// decodes packed 2-bit genotype bytes of one marker, stores the included
// calls, and returns the marker mean and mean-imputed dosages
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): a load request carries one packed
//   byte, its four include bits and a last-byte mark; a read request asks
//   for the next stored dosage. cfg_we / cfg_data set the slot total; the
//   user must write it only while idle, the block does not enforce this
//   output channel (out_valid / out_stall): a marker summary after each
//   last-marked byte, or one dosage for each read request
//   loads: one byte (four slots, four lanes) per cycle while no read or
//   summary is pending, no result unless marked last
//   last byte: the mean comes from a one-bit-per-cycle divider, and the
//   summary goes into the output register once it is done and that
//   register is free; no request is taken meanwhile
//   reads: the bank read is registered at acceptance, and the dosage moves
//   on into the output register before the next request is taken
//   a receiver stall holds the output register; the block still takes the
//   next request, and a request with a result waits in its state until the
//   output register is free
//   reset: counters, read pointer and mean go to zero, the slot total to
//   4096; the call store itself is not cleared
// ----------------------------------------------------------------------------
module packed_genotype_decode_impute (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [7:0]                      geno_byte,
	input  logic [3:0]                      include_mask,
	input  logic                            last_byte,
	input  logic                            cfg_we,
	input  logic [pgdi_pkg::CNT_W-1:0]      cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            result_kind,
	output logic [pgdi_pkg::DOS_W-1:0]      dosage,
	output logic [pgdi_pkg::CNT_W-1:0]      missing_total,
	output logic [pgdi_pkg::CNT_W-1:0]      tested_total,
	output logic                            all_missing,
	output logic                            list_end
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;

	// marker state
	logic [1:0]                   state_q;
	logic [pgdi_pkg::CNT_W-1:0]   total_q;
	logic [pgdi_pkg::CNT_W-1:0]   slot_q;
	logic [pgdi_pkg::CNT_W-1:0]   stored_q;
	logic [pgdi_pkg::CNT_W-1:0]   rp_q;
	logic [pgdi_pkg::CNT_W-1:0]   miss_q;
	logic [pgdi_pkg::SUM_W-1:0]   sum_q;
	logic [pgdi_pkg::DOS_W-1:0]   mean_q;
	logic                         done_q;
	logic                         none_q;
	logic                         hit_q;
	logic                         end_q;
	logic [pgdi_pkg::BANK_W-1:0]  rd_bank_q;
	pgdi_pkg::code_t              rd_code_q [pgdi_pkg::LANES];
	logic                         out_valid_q;

	// handshake
	logic in_acc, load_acc, read_acc, out_free, out_load_div, out_load_rd;

	// per-byte decode
	logic [pgdi_pkg::CNT_W-1:0]   eff_total;
	logic [pgdi_pkg::CNT_W-1:0]   base_slot, base_stored, base_miss;
	logic [pgdi_pkg::SUM_W-1:0]   base_sum;
	logic [pgdi_pkg::CNT_W-1:0]   slot_idx  [pgdi_pkg::LANES];
	logic [pgdi_pkg::CNT_W-1:0]   store_idx [pgdi_pkg::LANES];
	pgdi_pkg::lane_res_t          res       [pgdi_pkg::LANES];
	pgdi_pkg::merge_t             mrg;
	logic [pgdi_pkg::CNT_W-1:0]   nxt_slot, nxt_stored, nxt_miss, den;
	logic [pgdi_pkg::SUM_W-1:0]   nxt_sum;
	logic                         none;

	// bank write ports
	logic                         bank_we   [pgdi_pkg::LANES];
	logic [pgdi_pkg::ROW_W-1:0]   bank_row  [pgdi_pkg::LANES];
	pgdi_pkg::code_t              bank_code [pgdi_pkg::LANES];

	// divider
	logic                         div_done;
	logic [pgdi_pkg::DOS_W-1:0]   div_quo;

	pgdi_pkg::code_t              rd_code;
	logic [pgdi_pkg::DOS_W-1:0]   rd_dosage;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign load_acc  = in_acc && (opcode == pgdi_pkg::OP_LOAD);
	assign read_acc  = in_acc && (opcode == pgdi_pkg::OP_READ);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load_div = (state_q == ST_DIV) && div_done && out_free;
	assign out_load_rd  = (state_q == ST_RD) && out_free;

	// totals above the store depth act as the depth
	assign eff_total = (total_q > pgdi_pkg::CNT_W'(pgdi_pkg::MAX_IND)) ?
		pgdi_pkg::CNT_W'(pgdi_pkg::MAX_IND) : total_q;

	// first load after a summary starts a fresh marker
	assign base_slot   = done_q ? '0 : slot_q;
	assign base_stored = done_q ? '0 : stored_q;
	assign base_miss   = done_q ? '0 : miss_q;
	assign base_sum    = done_q ? '0 : sum_q;

	// store position of each lane: stored count plus earlier candidates
	always_comb begin
		logic [pgdi_pkg::LANE_W-1:0] acc;
		acc = '0;
		for (int j = 0; j < pgdi_pkg::LANES; j++) begin
			slot_idx[j]  = base_slot + pgdi_pkg::CNT_W'(j);
			store_idx[j] = base_stored + pgdi_pkg::CNT_W'(acc);
			acc          = acc + pgdi_pkg::LANE_W'((slot_idx[j] < eff_total) &&
				include_mask[j]);
		end
	end

	for (genvar j = 0; j < pgdi_pkg::LANES; j++) begin : g_lane
		pgdi_lane u_lane (
			.code      (geno_byte[2*j +: 2]),
			.incl      (include_mask[j]),
			.slot_idx  (slot_idx[j]),
			.eff_total (eff_total),
			.store_idx (store_idx[j]),
			.res       (res[j])
		);
	end

	pgdi_merge u_merge (
		.res (res),
		.m   (mrg)
	);

	assign nxt_slot   = base_slot + pgdi_pkg::CNT_W'(mrg.n_slot);
	assign nxt_stored = base_stored + pgdi_pkg::CNT_W'(mrg.n_keep);
	assign nxt_miss   = base_miss + pgdi_pkg::CNT_W'(mrg.n_miss);
	assign nxt_sum    = base_sum + pgdi_pkg::SUM_W'(mrg.dose_add);
	assign den        = nxt_stored - nxt_miss;
	assign none       = (den == '0);

	// kept calls land on consecutive addresses, so each bank gets at most one
	always_comb begin
		for (int b = 0; b < pgdi_pkg::LANES; b++) begin
			bank_we[b]   = 1'b0;
			bank_row[b]  = '0;
			bank_code[b] = pgdi_pkg::CODE_HOM_A;
			for (int j = 0; j < pgdi_pkg::LANES; j++) begin
				if (load_acc && res[j].keep &&
					store_idx[j][pgdi_pkg::BANK_W-1:0] == pgdi_pkg::BANK_W'(b)) begin
					bank_we[b]   = 1'b1;
					bank_row[b]  = store_idx[j][pgdi_pkg::IDX_W-1:pgdi_pkg::BANK_W];
					bank_code[b] = geno_byte[2*j +: 2];
				end
			end
		end
	end

	// call store, interleaved over four banks by the low address bits
	for (genvar b = 0; b < pgdi_pkg::LANES; b++) begin : g_bank
		pgdi_pkg::code_t bank_mem [pgdi_pkg::ROWS];

		always_ff @(posedge clk) begin
			if (bank_we[b])
				bank_mem[bank_row[b]] <= bank_code[b];
			if (read_acc)
				rd_code_q[b] <= bank_mem[rp_q[pgdi_pkg::IDX_W-1:pgdi_pkg::BANK_W]];
		end
	end

	pgdi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load_acc && last_byte),
		.num    ({nxt_sum, {pgdi_pkg::FRAC_BITS{1'b0}}}),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// control and marker counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= pgdi_pkg::CNT_W'(pgdi_pkg::MAX_IND);
			slot_q   <= '0;
			stored_q <= '0;
			rp_q     <= '0;
			miss_q   <= '0;
			sum_q    <= '0;
			mean_q   <= '0;
			done_q   <= 1'b0;
			none_q   <= 1'b0;
			hit_q    <= 1'b0;
			end_q    <= 1'b0;
		end else begin
			if (cfg_we)
				total_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (load_acc) begin
						slot_q   <= nxt_slot;
						stored_q <= nxt_stored;
						miss_q   <= nxt_miss;
						sum_q    <= nxt_sum;
						// new marker or summary rewinds the read pointer
						if (done_q || last_byte)
							rp_q <= '0;
						if (done_q)
							mean_q <= '0;
						done_q <= last_byte;
						if (last_byte) begin
							none_q  <= none;
							state_q <= ST_DIV;
						end
					end else if (read_acc) begin
						hit_q   <= (rp_q < stored_q);
						end_q   <= (rp_q < stored_q) ?
							(rp_q + pgdi_pkg::CNT_W'(1) == stored_q) : 1'b1;
						if (rp_q < stored_q)
							rp_q <= rp_q + pgdi_pkg::CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					if (out_load_div) begin
						mean_q  <= none_q ? '0 : div_quo;
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (out_load_rd)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc)
			rd_bank_q <= rp_q[pgdi_pkg::BANK_W-1:0];
	end

	// missing call takes the current mean
	assign rd_code   = rd_code_q[rd_bank_q];
	assign rd_dosage = !hit_q ? '0 :
		(rd_code == pgdi_pkg::CODE_MISS) ? mean_q :
		{pgdi_pkg::dose_of(rd_code), {pgdi_pkg::FRAC_BITS{1'b0}}};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load_div || out_load_rd)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load_div) begin
			result_kind   <= pgdi_pkg::KIND_SUMMARY;
			dosage        <= none_q ? '0 : div_quo;
			missing_total <= miss_q;
			tested_total  <= stored_q;
			all_missing   <= none_q;
			list_end      <= 1'b0;
		end else if (out_load_rd) begin
			result_kind   <= pgdi_pkg::KIND_DOSAGE;
			dosage        <= rd_dosage;
			missing_total <= '0;
			tested_total  <= '0;
			all_missing   <= 1'b0;
			list_end      <= end_q;
		end
	end

	assign out_valid = out_valid_q;

	// read pointer never runs past the stored calls
	a_rp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= stored_q)
		else $error("read pointer beyond stored count");

	// a marker with no observed call reports mean zero
	a_none_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_kind == pgdi_pkg::KIND_SUMMARY && all_missing
		|-> dosage == '0)
		else $error("all-missing summary with non-zero mean");

	// missing calls are a subset of tested calls
	a_miss_le_tested: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_kind == pgdi_pkg::KIND_SUMMARY
		|-> missing_total <= tested_total)
		else $error("missing count above tested count");

endmodule

>>> tb/tb_packed_genotype_decode_impute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_genotype_decode_impute
// streams packed genotype bytes and dosage reads into the decoder, predicts
// every marker summary and imputed dosage, and checks each result as the
// block hands it over
// ----------------------------------------------------------------------------
// flow
//   directed table at the reset total, one short marker at a total above the
//   store size, then random phases over several totals and idling patterns
//   each phase is bracketed by a full drain of outstanding results
// ----------------------------------------------------------------------------
module tb_packed_genotype_decode_impute;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	// a last-marked load waits for the divider before its summary
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_ITEMS    = 60;
	localparam int N_PHASES       = 8;
	localparam int N_DIR          = 25;
	localparam int CLAMP_BYTES    = 16;

	localparam logic [pgdi_pkg::DOS_W-1:0] DOSE_TWO =
		pgdi_pkg::DOS_W'(2) << pgdi_pkg::FRAC_BITS;
	localparam logic [pgdi_pkg::DOS_W-1:0] DOSE_ONE =
		pgdi_pkg::DOS_W'(1) << pgdi_pkg::FRAC_BITS;

	// one request on the input channel
	typedef struct packed {
		logic       op;
		logic [7:0] gb;
		logic [3:0] im;
		logic       lb;
	} req_t;

	// one result on the output channel
	typedef struct packed {
		logic                       kind;
		logic [pgdi_pkg::DOS_W-1:0] dos;
		logic [pgdi_pkg::CNT_W-1:0] miss;
		logic [pgdi_pkg::CNT_W-1:0] tested;
		logic                       allm;
		logic                       lend;
	} result_t;

	typedef struct packed {
		req_t    req;
		logic    typed;
		result_t res;
	} dir_row_t;

	localparam req_t READ_REQ = '{pgdi_pkg::OP_READ, 8'h00, 4'h0, 1'b0};

	// results that can be read straight off the decoding rules
	localparam result_t RD_PAST_END  =
		'{pgdi_pkg::KIND_DOSAGE, '0, '0, '0, 1'b0, 1'b1};
	localparam result_t RD_TWO_MORE  =
		'{pgdi_pkg::KIND_DOSAGE, DOSE_TWO, '0, '0, 1'b0, 1'b0};
	localparam result_t RD_ONE_MORE  =
		'{pgdi_pkg::KIND_DOSAGE, DOSE_ONE, '0, '0, 1'b0, 1'b0};
	localparam result_t RD_ZERO_MORE =
		'{pgdi_pkg::KIND_DOSAGE, '0, '0, '0, 1'b0, 1'b0};
	localparam result_t RD_ZERO_END  =
		'{pgdi_pkg::KIND_DOSAGE, '0, '0, '0, 1'b0, 1'b1};
	localparam result_t SUM_EMPTY    =
		'{pgdi_pkg::KIND_SUMMARY, '0, '0, '0, 1'b1, 1'b0};
	localparam result_t SUM_MISS4    =
		'{pgdi_pkg::KIND_SUMMARY, '0, pgdi_pkg::CNT_W'(4), pgdi_pkg::CNT_W'(4),
		1'b1, 1'b0};
	localparam result_t SUM_HET2     =
		'{pgdi_pkg::KIND_SUMMARY, DOSE_ONE, '0, pgdi_pkg::CNT_W'(2), 1'b0, 1'b0};

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic                          opcode       = pgdi_pkg::OP_LOAD;
	logic [7:0]                    geno_byte    = 8'h00;
	logic [3:0]                    include_mask = 4'h0;
	logic                          last_byte    = 1'b0;
	logic                          cfg_we       = 1'b0;
	logic [pgdi_pkg::CNT_W-1:0]    cfg_data     = '0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic                          result_kind;
	logic [pgdi_pkg::DOS_W-1:0]    dosage;
	logic [pgdi_pkg::CNT_W-1:0]    missing_total;
	logic [pgdi_pkg::CNT_W-1:0]    tested_total;
	logic                          all_missing;
	logic                          list_end;

	// predicted block state, reset values
	pgdi_pkg::code_t               call_mem [pgdi_pkg::MAX_IND];
	int unsigned                   p_stored = 0;
	int unsigned                   p_slots  = 0;
	int unsigned                   p_rdptr  = 0;
	int unsigned                   p_sum    = 0;
	int unsigned                   p_miss   = 0;
	logic [pgdi_pkg::DOS_W-1:0]    p_mean   = '0;
	bit                            p_done   = 1'b0;
	logic [pgdi_pkg::CNT_W-1:0]    p_total  = pgdi_pkg::CNT_W'(4096);

	result_t                       results_due [$];
	int                            err_count    = 0;
	int unsigned                   n_issued     = 0;
	int unsigned                   quiet_cycles = 0;
	int                            in_pct       = 0;
	int                            out_pct      = 0;
	bit                            hold_req     = 1'b0;
	bit                            hold_seen    = 1'b0;
	int                            hold_left    = 0;

	logic [pgdi_pkg::CNT_W-1:0]    phase_totals [N_PHASES] = '{
		pgdi_pkg::CNT_W'(1), pgdi_pkg::CNT_W'(0), pgdi_pkg::CNT_W'(5),
		pgdi_pkg::CNT_W'(13), pgdi_pkg::CNT_W'(4096), pgdi_pkg::CNT_W'(2),
		pgdi_pkg::CNT_W'(30), pgdi_pkg::CNT_W'(7)
	};

	// directed walk at the reset total of 4096
	dir_row_t                      dir_rows [N_DIR] = '{
		'{READ_REQ, 1'b1, RD_PAST_END},                          // read with nothing stored
		'{'{pgdi_pkg::OP_LOAD, 8'h00, 4'h0, 1'b1}, 1'b1, SUM_EMPTY}, // every slot excluded
		'{'{pgdi_pkg::OP_LOAD, 8'hE4, 4'hF, 1'b0}, 1'b0, '0},    // one of each code
		'{READ_REQ, 1'b1, RD_TWO_MORE},                          // reads before the summary
		'{READ_REQ, 1'b1, RD_ZERO_MORE},                         // missing: mean of new marker
		'{READ_REQ, 1'b1, RD_ONE_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_END},
		'{READ_REQ, 1'b1, RD_PAST_END},
		'{'{pgdi_pkg::OP_LOAD, 8'hFF, 4'hF, 1'b1}, 1'b0, '0},    // summary over both bytes
		'{READ_REQ, 1'b1, RD_TWO_MORE},                          // pointer rewound
		'{READ_REQ, 1'b0, '0},                                   // missing call takes the mean
		'{READ_REQ, 1'b1, RD_ONE_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_MORE},
		'{READ_REQ, 1'b1, RD_ZERO_END},
		'{READ_REQ, 1'b1, RD_PAST_END},
		'{'{pgdi_pkg::OP_LOAD, 8'h55, 4'hF, 1'b1}, 1'b1, SUM_MISS4}, // new marker, all missing
		'{READ_REQ, 1'b1, RD_ZERO_MORE},
		'{'{pgdi_pkg::OP_LOAD, 8'hAA, 4'hA, 1'b1}, 1'b1, SUM_HET2},  // odd slots only
		'{'{pgdi_pkg::OP_LOAD, 8'h1B, 4'h5, 1'b1}, 1'b0, '0},    // last mark after last mark
		'{READ_REQ, 1'b0, '0},
		'{READ_REQ, 1'b0, '0},
		'{READ_REQ, 1'b1, RD_PAST_END}
	};

	packed_genotype_decode_impute DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.geno_byte     (geno_byte),
		.include_mask  (include_mask),
		.last_byte     (last_byte),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.dosage        (dosage),
		.missing_total (missing_total),
		.tested_total  (tested_total),
		.all_missing   (all_missing),
		.list_end      (list_end)
	);

	always #1 clk = ~clk;

	// decode one request into the predicted state; returns 1 if it yields a result
	function automatic bit impute_predict(input req_t r, output result_t res);
		pgdi_pkg::code_t c;
		int unsigned     eff;
		int unsigned     observed;
		res = '0;
		if (r.op == pgdi_pkg::OP_READ) begin
			res.kind = pgdi_pkg::KIND_DOSAGE;
			if (p_rdptr < p_stored) begin
				c = call_mem[p_rdptr];
				case (c)
					pgdi_pkg::CODE_HOM_A: res.dos = DOSE_TWO;
					pgdi_pkg::CODE_HET:   res.dos = DOSE_ONE;
					pgdi_pkg::CODE_HOM_B: res.dos = '0;
					default:              res.dos = p_mean;
				endcase
				res.lend = (p_rdptr + 1 == p_stored);
				p_rdptr++;
			end else begin
				res.lend = 1'b1;
			end
			return 1'b1;
		end
		// first load after a summary starts a new marker
		if (p_done) begin
			p_stored = 0;
			p_slots  = 0;
			p_rdptr  = 0;
			p_sum    = 0;
			p_miss   = 0;
			p_mean   = '0;
			p_done   = 1'b0;
		end
		eff = (p_total > pgdi_pkg::MAX_IND) ? pgdi_pkg::MAX_IND : p_total;
		for (int j = 0; j < 4; j++) begin
			c = r.gb[2*j +: 2];
			if (p_slots < eff) begin
				p_slots++;
				if (r.im[j] && p_stored < pgdi_pkg::MAX_IND) begin
					call_mem[p_stored] = c;
					p_stored++;
					case (c)
						pgdi_pkg::CODE_HOM_A: p_sum += 2;
						pgdi_pkg::CODE_HET:   p_sum += 1;
						pgdi_pkg::CODE_MISS:  p_miss++;
						default:              ;
					endcase
				end
			end
		end
		if (!r.lb)
			return 1'b0;
		observed = p_stored - p_miss;
		if (observed == 0)
			p_mean = '0;
		else
			p_mean = pgdi_pkg::DOS_W'((64'(p_sum) << pgdi_pkg::FRAC_BITS) / observed);
		p_rdptr    = 0;
		p_done     = 1'b1;
		res.kind   = pgdi_pkg::KIND_SUMMARY;
		res.dos    = p_mean;
		res.miss   = pgdi_pkg::CNT_W'(p_miss);
		res.tested = pgdi_pkg::CNT_W'(p_stored);
		res.allm   = (observed == 0);
		return 1'b1;
	endfunction

	// offer one request, wait for it to be taken, note what it should produce
	task automatic issue(input req_t r, input bit typed, input result_t typed_res);
		result_t res;
		while ($urandom_range(0, 99) < in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= r.op;
		geno_byte    <= r.gb;
		include_mask <= r.im;
		last_byte    <= r.lb;
		do
			@(posedge clk);
		while (in_stall);
		if (impute_predict(r, res))
			results_due = {results_due, (typed ? typed_res : res)};
		n_issued++;
	endtask

	// stop offering and let every outstanding result drain out
	task automatic settle();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_total(input logic [pgdi_pkg::CNT_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		p_total = v;
	endtask

	// mostly random bytes, with the uniform patterns mixed in
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			6:       return 8'h00;
			7:       return 8'h55;
			8:       return 8'hAA;
			9:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one well-formed marker at the current total, then read its list back
	task automatic random_marker();
		int unsigned eff;
		int unsigned nb;
		int unsigned b;
		logic [3:0]  m;
		eff = (p_total > pgdi_pkg::MAX_IND) ? pgdi_pkg::MAX_IND : p_total;
		nb  = (eff + 3) / 4;
		if (nb == 0)
			nb = $urandom_range(1, 3);
		else if (nb > 16)
			nb = $urandom_range(1, 16);   // big totals: cut the marker short
		for (b = 0; b < nb; b++) begin
			if ($urandom_range(0, 9) == 0)
				issue(READ_REQ, 1'b0, '0);
			m = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom_range(0, 15));
			issue('{pgdi_pkg::OP_LOAD, pick_byte(), m, b == nb - 1}, 1'b0, '0);
		end
		repeat (p_stored + $urandom_range(0, 1)) issue(READ_REQ, 1'b0, '0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (results_due.size() == 0) begin
			$error("unexpected result: kind %0d dosage %0d", result_kind, dosage);
			err_count++;
		end else begin
			want = results_due.pop_front();
			check_field("result_kind", 32'(want.kind), 32'(result_kind));
			check_field("dosage", 32'(want.dos), 32'(dosage));
			check_field("missing_total", 32'(want.miss), 32'(missing_total));
			check_field("tested_total", 32'(want.tested), 32'(tested_total));
			check_field("all_missing", 32'(want.allm), 32'(all_missing));
			check_field("list_end", 32'(want.lend), 32'(list_end));
		end
	endtask

	// receiver: checks each result taken, stalls at random or for a long hold
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall == 1'b0)
			check_result();
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_pct);
		end
	end

	// watchdog on cycles with no request and no result taken
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int unsigned goal;
		logic [3:0]  m;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk, no idling
		for (int i = 0; i < N_DIR; i++)
			issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
		settle();

		// total above the store size acts as the store size,
		// all calls homozygous so the mean sits at its top value
		write_total(pgdi_pkg::CNT_W'(8191));
		repeat (CLAMP_BYTES - 1)
			issue('{pgdi_pkg::OP_LOAD, 8'h00, 4'hF, 1'b0}, 1'b0, '0);
		issue('{pgdi_pkg::OP_LOAD, 8'h00, 4'hF, 1'b1}, 1'b0, '0);
		repeat (4 * CLAMP_BYTES + 1) issue(READ_REQ, 1'b0, '0);
		settle();

		// random phases, each with its own total and idling pattern
		for (int p = 0; p < N_PHASES; p++) begin
			write_total(phase_totals[p]);
			case (p % 4)
				0: begin in_pct = 0;  out_pct = 0;  end
				1: begin in_pct = 48; out_pct = 0;  end
				2: begin in_pct = 0;  out_pct = 48; end
				default: begin in_pct = 16; out_pct = 16; end
			endcase
			// long receiver hold while requests keep coming, so the block backs up
			if (p == 2)
				hold_req = ~hold_req;
			goal = n_issued + PHASE_ITEMS;
			while (n_issued < goal) begin
				if ($urandom_range(0, 99) < 85) begin
					random_marker();
				end else begin
					m = 4'($urandom_range(0, 15));
					issue('{1'($urandom_range(0, 1)), pick_byte(), m,
						$urandom_range(0, 4) == 0}, 1'b0, '0);
				end
			end
			settle();
		end

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> packed_genotype_decode_impute.f
sv/pgdi_pkg.sv
sv/pgdi_lane.sv
sv/pgdi_merge.sv
sv/pgdi_div.sv
sv/packed_genotype_decode_impute.sv
tb/tb_packed_genotype_decode_impute.sv
